/* sv/paren_depth_terminal_colorizer_macros.svh */
// Assertion macros for the colorizer checker.
`ifndef PAREN_DEPTH_TERMINAL_COLORIZER_MACROS_SVH
`define PAREN_DEPTH_TERMINAL_COLORIZER_MACROS_SVH

// Check cons at the edge where ante holds, outside reset.
`define PDTC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("colorizer check failed");

// Check cons at the edge after the one where ante holds, outside reset.
`define PDTC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("colorizer check failed");

// Check cons at every edge while reset is applied.
`define PDTC_ASSERT_RST(lbl, cons) \
	lbl: assert property (@(posedge clk) (!arst_n) |-> (cons)) \
		else $error("colorizer reset check failed");

`endif

/* sv/pdtc_pkg.sv */
package pdtc_pkg;

	localparam int DEPTH_LIMIT_DEF  = 127;
	localparam int PALETTE_SIZE_DEF = 8;
	localparam int DEPTH_W          = 7;
	localparam int QUEUE_DEPTH      = 4;
	localparam int QPTR_W           = 2;
	localparam int SEG_COUNT        = 9;

	localparam logic [7:0] CH_ESC    = 8'h1B;
	localparam logic [7:0] CH_LBRK   = 8'h5B;
	localparam logic [7:0] CH_THREE  = 8'h33;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_M      = 8'h6D;
	localparam logic [7:0] CH_D      = 8'h44;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_AT     = 8'h40;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_K      = 8'h6B;

	localparam logic [3:0] COLOR_GREEN   = 4'd2;
	localparam logic [3:0] COLOR_CYAN    = 4'd6;
	localparam logic [3:0] COLOR_DEFAULT = 4'd9;

	typedef struct packed {
		logic       banner;
		logic       paren;
		logic [3:0] paren_color;
		logic       crlf;
		logic       cyan;
		logic       green;
		logic       backup;
		logic [7:0] prev_byte;
		logic [7:0] chr;
	} cmd_t;

	typedef enum logic [3:0] {
		SEG_IDLE,
		SEG_BANNER,
		SEG_RESET,
		SEG_PAREN,
		SEG_CRLF,
		SEG_CYAN,
		SEG_GREEN,
		SEG_BACK,
		SEG_CHAR
	} seg_t;

	function automatic logic is_punct_char(logic [7:0] b);
		return (b > 8'd32 && b < 8'd48 && b != CH_LPAREN && b != CH_RPAREN) ||
			(b > 8'd57 && b < 8'd65) ||
			(b > 8'd90 && b < 8'd97) ||
			(b > 8'd122 && b < 8'd127);
	endfunction

	function automatic logic is_digit(logic [7:0] b);
		return (b >= CH_ZERO) && (b <= CH_NINE);
	endfunction

	function automatic logic [3:0] seg_last(seg_t s);
		logic [3:0] r;
		unique case (s) inside
			SEG_BANNER: r = 4'd6;
			SEG_RESET, SEG_PAREN, SEG_CYAN, SEG_GREEN: r = 4'd4;
			SEG_CRLF: r = 4'd1;
			SEG_BACK: r = 4'd8;
			default: r = 4'd0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] color_byte(logic [3:0] idx, logic [3:0] c);
		logic [7:0] r;
		unique case (idx)
			4'd1: r = CH_LBRK;
			4'd2: r = CH_THREE;
			4'd3: r = CH_ZERO + {4'd0, c};
			4'd4: r = CH_M;
			default: r = CH_ESC;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] banner_byte(logic [3:0] idx);
		logic [7:0] r;
		unique case (idx)
			4'd0: r = CH_AT;
			4'd1: r = CH_R;
			4'd2: r = CH_K;
			4'd3: r = CH_BANG;
			4'd4: r = CH_CR;
			4'd5: r = CH_LF;
			default: r = CH_LPAREN;
		endcase
		return r;
	endfunction

endpackage

/* sv/pdtc_front.sv */
module pdtc_front #(
	parameter int DEPTH_LIMIT  = pdtc_pkg::DEPTH_LIMIT_DEF,
	parameter int PALETTE_SIZE = pdtc_pkg::PALETTE_SIZE_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  logic [7:0]     in_byte,
	output logic           full,
	input  logic           q_full,
	output logic           q_wr,
	output pdtc_pkg::cmd_t q_data
);

	localparam int MOD_W = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
	localparam logic [MOD_W-1:0] MOD_TOP = MOD_W'(PALETTE_SIZE - 1);

	logic                        online_q;
	logic [pdtc_pkg::DEPTH_W-1:0] depth_q;
	logic [MOD_W-1:0]            mod_q;
	logic                        glyph_q;
	logic [7:0]                  prev_q;

	logic                        accept;
	logic                        glyph;
	logic                        is_lp;
	logic                        is_rp;
	logic                        can_inc;
	logic                        can_dec;
	logic                        echo;
	logic                        wake;
	logic [pdtc_pkg::DEPTH_W-1:0] depth_d;
	logic [MOD_W-1:0]            mod_up;
	logic [MOD_W-1:0]            mod_dn;
	logic [MOD_W-1:0]            mod_d;

	assign full   = q_full;
	assign accept = push && !q_full;
	assign glyph  = pdtc_pkg::is_punct_char(in_byte);
	assign is_lp  = (in_byte == pdtc_pkg::CH_LPAREN);
	assign is_rp  = (in_byte == pdtc_pkg::CH_RPAREN);
	assign echo   = online_q && (in_byte != 8'd0);
	assign wake   = !online_q && (in_byte == pdtc_pkg::CH_BANG);

	assign can_inc = ({1'b0, depth_q} < 8'(DEPTH_LIMIT)) && (depth_q != '1);
	assign can_dec = (depth_q != '0);
	assign mod_up  = !can_inc ? mod_q : ((mod_q == MOD_TOP) ? '0 : mod_q + 1'b1);
	assign mod_dn  = (mod_q == '0) ? MOD_TOP : mod_q - 1'b1;

	always_comb begin
		depth_d = depth_q;
		mod_d   = mod_q;
		if (is_lp) begin
			depth_d = can_inc ? depth_q + 1'b1 : depth_q;
			mod_d   = mod_up;
		end else if (is_rp && can_dec) begin
			depth_d = depth_q - 1'b1;
			mod_d   = mod_dn;
		end
	end

	always_comb begin
		q_wr               = accept && (echo || wake);
		q_data.banner      = !online_q;
		q_data.paren       = online_q && (is_lp || is_rp);
		if (is_lp) begin
			q_data.paren_color = 4'(mod_up) + 4'd1;
		end else if (can_dec) begin
			q_data.paren_color = 4'(mod_q) + 4'd1;
		end else begin
			q_data.paren_color = pdtc_pkg::COLOR_DEFAULT;
		end
		q_data.crlf        = online_q && (in_byte == pdtc_pkg::CH_CR);
		q_data.cyan        = online_q && pdtc_pkg::is_digit(in_byte);
		q_data.green       = online_q && (glyph || glyph_q);
		q_data.backup      = online_q && glyph && !glyph_q;
		q_data.prev_byte   = prev_q;
		q_data.chr         = in_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			online_q <= 1'b0;
			depth_q  <= '0;
			mod_q    <= '0;
			glyph_q  <= 1'b0;
			prev_q   <= '0;
		end else if (accept) begin
			if (wake) begin
				online_q <= 1'b1;
			end
			if (echo) begin
				depth_q <= depth_d;
				mod_q   <= mod_d;
				glyph_q <= glyph;
				prev_q  <= in_byte;
			end
		end
	end

endmodule

/* sv/pdtc_queue.sv */
module pdtc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  pdtc_pkg::cmd_t wr_data,
	output logic           full,
	input  logic           rd_en,
	output pdtc_pkg::cmd_t rd_data,
	output logic           empty
);

	logic [pdtc_pkg::QPTR_W:0] wr_ptr_q;
	logic [pdtc_pkg::QPTR_W:0] rd_ptr_q;
	pdtc_pkg::cmd_t            mem_q [pdtc_pkg::QUEUE_DEPTH];

	assign empty = (wr_ptr_q == rd_ptr_q);
	assign full  = (wr_ptr_q[pdtc_pkg::QPTR_W] != rd_ptr_q[pdtc_pkg::QPTR_W]) &&
		(wr_ptr_q[pdtc_pkg::QPTR_W-1:0] == rd_ptr_q[pdtc_pkg::QPTR_W-1:0]);
	assign rd_data = mem_q[rd_ptr_q[pdtc_pkg::QPTR_W-1:0]];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q[pdtc_pkg::QPTR_W-1:0]] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
		end
	end

endmodule

/* sv/pdtc_back.sv */
module pdtc_back (
	input  logic           clk,
	input  logic           arst_n,
	input  pdtc_pkg::cmd_t q_data,
	input  logic           q_empty,
	output logic           q_rd,
	output logic           empty,
	input  logic           pop,
	output logic [7:0]     out_byte,
	output logic           last_of_run
);

	pdtc_pkg::seg_t seg_q;
	pdtc_pkg::seg_t seg_d;
	pdtc_pkg::seg_t nxt;
	logic [3:0]     cnt_q;
	logic [3:0]     cnt_d;
	pdtc_pkg::cmd_t cur_q;
	logic           valid_q;
	logic [7:0]     byte_q;
	logic           last_q;

	logic [pdtc_pkg::SEG_COUNT-1:0] pres;
	logic           adv;
	logic           seg_end;
	logic           run_end;
	logic [7:0]     byte_c;

	assign empty       = !valid_q;
	assign out_byte    = byte_q;
	assign last_of_run = last_q;

	always_comb begin
		pres                      = '0;
		pres[pdtc_pkg::SEG_BANNER] = cur_q.banner;
		pres[pdtc_pkg::SEG_RESET]  = !cur_q.banner;
		pres[pdtc_pkg::SEG_PAREN]  = cur_q.paren;
		pres[pdtc_pkg::SEG_CRLF]   = cur_q.crlf;
		pres[pdtc_pkg::SEG_CYAN]   = cur_q.cyan;
		pres[pdtc_pkg::SEG_GREEN]  = cur_q.green;
		pres[pdtc_pkg::SEG_BACK]   = cur_q.backup;
		pres[pdtc_pkg::SEG_CHAR]   = !cur_q.banner;
		nxt = pdtc_pkg::SEG_IDLE;
		for (int i = pdtc_pkg::SEG_COUNT - 1; i > 0; i--) begin
			if (pres[i] && (4'(i) > seg_q)) begin
				nxt = pdtc_pkg::seg_t'(4'(i));
			end
		end
	end

	assign adv     = (seg_q != pdtc_pkg::SEG_IDLE) && (!valid_q || pop);
	assign seg_end = (cnt_q == pdtc_pkg::seg_last(seg_q));
	assign run_end = seg_end && (nxt == pdtc_pkg::SEG_IDLE);
	assign q_rd    = !q_empty && ((seg_q == pdtc_pkg::SEG_IDLE) || (adv && run_end));

	// next state
	always_comb begin
		seg_d = seg_q;
		cnt_d = cnt_q;
		if (adv) begin
			if (seg_end) begin
				seg_d = nxt;
				cnt_d = '0;
			end else begin
				cnt_d = cnt_q + 1'b1;
			end
		end
		if (q_rd) begin
			seg_d = q_data.banner ? pdtc_pkg::SEG_BANNER : pdtc_pkg::SEG_RESET;
			cnt_d = '0;
		end
	end

	// outputs
	always_comb begin
		unique case (seg_q)
			pdtc_pkg::SEG_BANNER: byte_c = pdtc_pkg::banner_byte(cnt_q);
			pdtc_pkg::SEG_RESET:  byte_c = pdtc_pkg::color_byte(cnt_q, pdtc_pkg::COLOR_DEFAULT);
			pdtc_pkg::SEG_PAREN:  byte_c = pdtc_pkg::color_byte(cnt_q, cur_q.paren_color);
			pdtc_pkg::SEG_CRLF:   byte_c = (cnt_q == 4'd0) ? pdtc_pkg::CH_CR : pdtc_pkg::CH_LF;
			pdtc_pkg::SEG_CYAN:   byte_c = pdtc_pkg::color_byte(cnt_q, pdtc_pkg::COLOR_CYAN);
			pdtc_pkg::SEG_GREEN:  byte_c = pdtc_pkg::color_byte(cnt_q, pdtc_pkg::COLOR_GREEN);
			pdtc_pkg::SEG_BACK: begin
				if (cnt_q == 4'd0) begin
					byte_c = pdtc_pkg::CH_ESC;
				end else if (cnt_q == 4'd1) begin
					byte_c = pdtc_pkg::CH_LBRK;
				end else if (cnt_q == 4'd2) begin
					byte_c = pdtc_pkg::CH_D;
				end else if (cnt_q == 4'd8) begin
					byte_c = cur_q.prev_byte;
				end else begin
					byte_c = pdtc_pkg::color_byte(cnt_q - 4'd3, pdtc_pkg::COLOR_GREEN);
				end
			end
			default: byte_c = cur_q.chr;
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_rd) begin
			cur_q <= q_data;
		end
		if (adv) begin
			byte_q <= byte_c;
			last_q <= run_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q   <= pdtc_pkg::SEG_IDLE;
			cnt_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			seg_q <= seg_d;
			cnt_q <= cnt_d;
			if (adv) begin
				valid_q <= 1'b1;
			end else if (pop) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

/* sv/paren_depth_terminal_colorizer.sv */
// Serial terminal colorizer. Drops bytes until '!', then sends the banner
// "@rk!" CR LF "(" and from then on echoes each nonzero byte behind ANSI color
// escapes: parentheses by nesting depth, digits cyan, punctuation green with a
// cursor back-up and reprint of the previous byte when a punctuation run starts.
// The banner is 7 output words and each echoed byte yields 6 to 20; the output
// side sends one word per cycle while pop takes them, so the words each byte
// yields in the output sequencer set the sustained rate. Input bytes are taken every cycle
// while the 4-entry command queue between the classifier and the sequencer has
// room; dropped bytes take no queue slot.
module paren_depth_terminal_colorizer #(
	parameter int DEPTH_LIMIT  = pdtc_pkg::DEPTH_LIMIT_DEF,
	parameter int PALETTE_SIZE = pdtc_pkg::PALETTE_SIZE_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_byte,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       last_of_run
);

	logic           q_full;
	logic           q_empty;
	logic           q_wr;
	logic           q_rd;
	pdtc_pkg::cmd_t q_wdata;
	pdtc_pkg::cmd_t q_rdata;

	pdtc_front #(
		.DEPTH_LIMIT  (DEPTH_LIMIT),
		.PALETTE_SIZE (PALETTE_SIZE)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.in_byte (in_byte),
		.full    (full),
		.q_full  (q_full),
		.q_wr    (q_wr),
		.q_data  (q_wdata)
	);

	pdtc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_wr),
		.wr_data (q_wdata),
		.full    (q_full),
		.rd_en   (q_rd),
		.rd_data (q_rdata),
		.empty   (q_empty)
	);

	pdtc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_data      (q_rdata),
		.q_empty     (q_empty),
		.q_rd        (q_rd),
		.empty       (empty),
		.pop         (pop),
		.out_byte    (out_byte),
		.last_of_run (last_of_run)
	);

endmodule

/* sv/pdtc_checker.sv */
`include "paren_depth_terminal_colorizer_macros.svh"

module pdtc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       full,
	input logic       empty,
	input logic       pop,
	input logic [7:0] out_byte,
	input logic       last_of_run
);

	// hold a waiting word until taken
	`PDTC_ASSERT_NXT(a_hold, !empty && !pop, !empty && $stable(out_byte) && $stable(last_of_run))

	// words of one run follow without a gap
	`PDTC_ASSERT_NXT(a_run_gapless, pop && !empty && !last_of_run, !empty)

	`PDTC_ASSERT_RST(a_rst_empty, empty)

	`PDTC_ASSERT_RST(a_rst_not_full, !full)

endmodule

bind paren_depth_terminal_colorizer pdtc_checker u_pdtc_checker (.*);

/* tb/tb_paren_depth_terminal_colorizer.sv */
`timescale 1ns / 1ps

module tb_paren_depth_terminal_colorizer;
	import pdtc_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} word_t;

	typedef struct {
		logic [7:0] b;
		bit         typed;
		string      words;
	} row_t;

	logic       clk;
	logic       arst_n;
	logic       push;
	logic       full;
	logic [7:0] in_byte;
	logic       empty;
	logic       pop;
	logic [7:0] out_byte;
	logic       last_of_run;

	bit         typed_on;
	string      typed_words;

	logic       is_online;
	logic [6:0] nest;
	logic       last_punct;
	logic [7:0] last_char;

	logic [7:0]  run_q[$];
	word_t       echo_q[$];
	int          mismatches;
	int unsigned push_calm;
	int unsigned pop_calm;
	int          sent_count;

	paren_depth_terminal_colorizer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.in_byte(in_byte),
		.empty(empty),
		.pop(pop),
		.out_byte(out_byte),
		.last_of_run(last_of_run)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#15ms;
		$display("paren_depth_terminal_colorizer regression: fail");
		$finish;
	end

	function automatic int unsigned pick_gap(inout int unsigned calm);
		int unsigned r;
		if (calm != 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm = $urandom_range(20, 60);
			return 0;
		end
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	function automatic bit is_punct(logic [7:0] b);
		if (b == CH_LPAREN || b == CH_RPAREN)
			return 1'b0;
		return b inside {[8'd33:8'd47], [8'd58:8'd64], [8'd91:8'd96], [8'd123:8'd126]};
	endfunction

	function automatic void add_color(logic [3:0] c);
		run_q.push_back(CH_ESC);
		run_q.push_back(CH_LBRK);
		run_q.push_back(CH_THREE);
		run_q.push_back(CH_ZERO + {4'd0, c});
		run_q.push_back(CH_M);
	endfunction

	function automatic logic [3:0] nest_color();
		return 4'((int'(nest) % PALETTE_SIZE_DEF) + 1);
	endfunction

	// Build the words one input byte produces and advance the predictor state.
	function automatic void colorize(logic [7:0] b);
		bit punct;
		run_q.delete();
		if (!is_online) begin
			if (b == CH_BANG) begin
				is_online = 1'b1;
				run_q = '{CH_AT, CH_R, CH_K, CH_BANG, CH_CR, CH_LF, CH_LPAREN};
			end
			return;
		end
		if (b == 8'd0)
			return;
		add_color(COLOR_DEFAULT);
		if (b == CH_LPAREN) begin
			if (int'(nest) < DEPTH_LIMIT_DEF)
				nest++;
			add_color(nest_color());
		end else if (b == CH_RPAREN) begin
			if (nest != 0) begin
				add_color(nest_color());
				nest--;
			end else begin
				add_color(COLOR_DEFAULT);
			end
		end else if (b == CH_CR) begin
			run_q.push_back(CH_CR);
			run_q.push_back(CH_LF);
		end
		if (b >= CH_ZERO && b <= CH_NINE)
			add_color(COLOR_CYAN);
		punct = is_punct(b);
		if (punct || last_punct)
			add_color(COLOR_GREEN);
		if (punct && !last_punct) begin
			run_q.push_back(CH_ESC);
			run_q.push_back(CH_LBRK);
			run_q.push_back(CH_D);
			add_color(COLOR_GREEN);
			run_q.push_back(last_char);
		end
		run_q.push_back(b);
		last_punct = punct;
		last_char = b;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				colorize(in_byte);
				if (typed_on) begin
					run_q.delete();
					for (int i = 0; i < typed_words.len(); i++)
						run_q.push_back(typed_words[i]);
				end
				foreach (run_q[i])
					echo_q.push_back('{data: run_q[i], last: (i == run_q.size() - 1)});
			end
			if (pop && !empty) begin
				if (echo_q.size() == 0) begin
					$error("out_byte: expected none, got %0h", out_byte);
					mismatches++;
				end else begin
					if (out_byte !== echo_q[0].data) begin
						$error("out_byte: expected %0h, got %0h", echo_q[0].data, out_byte);
						mismatches++;
					end
					if (last_of_run !== echo_q[0].last) begin
						$error("last_of_run: expected %0b, got %0b", echo_q[0].last,
							last_of_run);
						mismatches++;
					end
					void'(echo_q.pop_front());
				end
			end
		end
	end

	initial begin
		int unsigned stall;
		pop = 1'b0;
		stall = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall != 0) begin
				pop <= 1'b0;
				stall--;
			end else begin
				pop <= 1'b1;
				stall = pick_gap(pop_calm);
			end
		end
	end

	task automatic send_byte(input logic [7:0] v, input bit typed, input string words);
		int unsigned g;
		g = pick_gap(push_calm);
		repeat (g) begin
			@(negedge clk);
			push <= 1'b0;
		end
		@(negedge clk);
		push <= 1'b1;
		in_byte <= v;
		typed_on <= typed;
		typed_words <= words;
		do @(posedge clk); while (full);
	endtask

	task automatic send_rand(input logic [7:0] v);
		send_byte(v, 1'b0, "");
		if (v != 8'd0)
			sent_count++;
	endtask

	function automatic logic [7:0] pick_punct();
		logic [7:0] b;
		do b = 8'($urandom_range(33, 126)); while (!is_punct(b));
		return b;
	endfunction

	function automatic logic [7:0] pick_byte();
		logic [7:0] b;
		case ($urandom_range(0, 11))
			0, 1: b = 8'($urandom_range(32, 126));
			2, 3: b = pick_punct();
			4: b = 8'($urandom_range(48, 57));
			5: b = CH_CR;
			6: b = 8'd0;
			7: b = 8'($urandom_range(128, 255));
			8: b = CH_LPAREN;
			9: b = CH_RPAREN;
			10: b = 8'($urandom_range(0, 255));
			default: b = 8'($urandom_range(97, 122));
		endcase
		return b;
	endfunction

	initial begin
		row_t plan[$];
		arst_n = 1'b0;
		push = 1'b0;
		in_byte = 8'd0;
		typed_on = 1'b0;
		typed_words = "";
		is_online = 1'b0;
		nest = '0;
		last_punct = 1'b0;
		last_char = 8'd0;
		mismatches = 0;
		push_calm = 0;
		pop_calm = 0;
		sent_count = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		plan.push_back('{8'h41, 1'b1, ""});
		plan.push_back('{8'h00, 1'b1, ""});
		plan.push_back('{8'hFF, 1'b1, ""});
		plan.push_back('{CH_LPAREN, 1'b1, ""});
		plan.push_back('{CH_BANG, 1'b1, "@rk!\015\012("});
		plan.push_back('{CH_BANG, 1'b0, ""});
		plan.push_back('{8'h00, 1'b1, ""});
		plan.push_back('{8'h7E, 1'b1, "\033[39m\033[32m~"});
		plan.push_back('{8'h41, 1'b1, "\033[39m\033[32mA"});
		plan.push_back('{8'h35, 1'b1, "\033[39m\033[36m5"});
		plan.push_back('{CH_RPAREN, 1'b1, "\033[39m\033[39m)"});
		plan.push_back('{CH_LPAREN, 1'b1, "\033[39m\033[32m("});
		plan.push_back('{CH_LPAREN, 1'b0, ""});
		plan.push_back('{CH_RPAREN, 1'b0, ""});
		plan.push_back('{CH_RPAREN, 1'b1, "\033[39m\033[32m)"});
		plan.push_back('{CH_CR, 1'b1, "\033[39m\015\012\015"});
		plan.push_back('{8'hFF, 1'b1, "\033[39m\377"});
		plan.push_back('{8'h2B, 1'b1, "\033[39m\033[32m\033[D\033[32m\377+"});
		plan.push_back('{8'h39, 1'b0, ""});
		plan.push_back('{8'h80, 1'b1, "\033[39m\200"});
		plan.push_back('{8'h2F, 1'b0, ""});
		plan.push_back('{8'h3A, 1'b0, ""});
		plan.push_back('{8'h40, 1'b0, ""});
		plan.push_back('{8'h5B, 1'b0, ""});
		plan.push_back('{8'h7B, 1'b0, ""});
		plan.push_back('{8'h20, 1'b0, ""});
		plan.push_back('{8'h60, 1'b0, ""});
		plan.push_back('{8'h7F, 1'b0, ""});
		foreach (plan[i])
			send_byte(plan[i].b, plan[i].typed, plan[i].words);

		// Nest past the depth limit with random text mixed in.
		for (int i = 0; i < 135; i++) begin
			send_rand(CH_LPAREN);
			if ($urandom_range(0, 2) == 0)
				send_rand(pick_byte());
		end
		while (sent_count < 280) begin
			case ($urandom_range(0, 5))
				0: repeat ($urandom_range(1, 12)) send_rand(CH_RPAREN);
				1: repeat ($urandom_range(1, 6)) send_rand(CH_LPAREN);
				2: repeat ($urandom_range(1, 5)) send_rand(pick_punct());
				default: send_rand(pick_byte());
			endcase
		end
		@(negedge clk);
		push <= 1'b0;

		while (echo_q.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (mismatches == 0)
			$display("paren_depth_terminal_colorizer regression: pass");
		else
			$display("paren_depth_terminal_colorizer regression: fail");
		$finish;
	end

endmodule
